### hdl/qphs_pkg.sv
// ----------------------------------------------------------------------------
// qphs_pkg - shared types and constants of the quadratic probe hash set
// Operation, result and slot state codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package qphs_pkg;

  localparam int CfgW     = 11;
  localparam int SlotW    = 10;
  localparam int StatusW  = 3;
  localparam int OpW      = 2;
  localparam int OutDataW = ((SlotW + 7) / 8) * 8;

  localparam logic [CfgW-1:0] CfgResetVal = 11'd11;

  // Configuration register indexes
  localparam logic RegTableSize = 1'b0;
  localparam logic RegHashDiv   = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    RES_INSERTED    = 3'd0,
    RES_PRESENT     = 3'd1,
    RES_FULL        = 3'd2,
    RES_DELETED     = 3'd3,
    RES_NOT_PRESENT = 3'd4,
    RES_FOUND       = 3'd5,
    RES_NOT_FOUND   = 3'd6
  } res_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_VALID   = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_e;

endpackage

### hdl/qphs_ram.sv
// ----------------------------------------------------------------------------
// qphs_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module qphs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/qphs_rem.sv
// ----------------------------------------------------------------------------
// qphs_rem - iterative remainder unit
// Restoring division, one dividend bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module qphs_rem #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;

  // Shift in the next dividend bit, subtract the divisor if it fits
  assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = DIVISOR_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### hdl/quadratic_probe_hash_set.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_set - open-addressed key set with quadratic probing
// Insert, delete or look up a key; home slot is (key mod divisor) mod table
// size, then probes step +1, -1, +4, -4 and so on, wrapped modulo the table size.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries                            Handshake
//  s_axis    in         tuser: opcode; tdata: key          tvalid / tready
//  m_axis    out        tuser: status; tdata: slot         tvalid / tready
//  cfg       in         index 0 table_size, 1 hash_divisor cfg_valid_i / cfg_ready_o
//
//  A request runs two remainder passes on the remainder unit, whose dividend
//  width DVW is KEY_WIDTH, at least the divisor width. Each probe then reads,
//  checks and steps (the last has no step); then the block posts the result
//  and returns to idle.
//  After reset, sweep the slot RAM to empty; hold off requests meanwhile,
//  take configuration writes. A stalled result holds the block in its final
//  step; never drop or repeat a result.
//
module quadratic_probe_hash_set
  import qphs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 31,
  localparam int KeyDataW   = ((KEY_WIDTH + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [KeyDataW-1:0] s_axis_tdata,   // [KEY_WIDTH-1:0] key, rest zero
  input  logic [OpW-1:0]      s_axis_tuser,   // [1:0] opcode
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [9:0] slot, rest zero
  output logic [StatusW-1:0]  m_axis_tuser,   // [2:0] status
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int NW   = AW + 1;                       // holds the table size itself
  localparam int DW   = (NW > CfgW) ? NW : CfgW;      // remainder unit divisor width
  localparam int DVW  = (KEY_WIDTH > DW) ? KEY_WIDTH : DW;
  localparam int RamW = KEY_WIDTH + 2;                // {key, slot state}

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [CfgW-1:0]      cfg_size_q, cfg_size_d;
  logic [CfgW-1:0]      cfg_div_q, cfg_div_d;
  logic [AW-1:0]        clr_q, clr_d;

  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [NW-1:0]        home_q, home_d;
  logic [NW-1:0]        cur_q, cur_d;
  logic [NW-1:0]        sq_q, sq_d;
  logic [NW:0]          odd_q, odd_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic                 plus_q, plus_d;
  logic                 hit_q, hit_d;
  slot_st_e             st_q, st_d;

  logic                 out_valid_q, out_valid_d;
  res_e                 out_status_q, out_status_d;
  logic [SlotW-1:0]     out_slot_q, out_slot_d;

  logic [NW-1:0]        n_eff;
  logic [DW-1:0]        d_eff;

  logic                 rem_start;
  logic [DVW-1:0]       rem_dividend;
  logic [DW-1:0]        rem_divisor;
  logic                 rem_done;
  logic [DW-1:0]        rem_val;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RamW-1:0]      ram_wdata;
  logic                 ram_re;
  logic [RamW-1:0]      ram_rdata;
  slot_st_e             rd_st;
  logic                 rd_stop;

  logic [NW:0]          sq_sum;
  logic [NW:0]          pos_sum;
  logic [SlotW+NW-1:0]  slot_ext;
  logic                 in_acc;
  logic                 out_free;

  // --------------------------------------------------------------------------
  // Effective table size and divisor: clamp size to 1..TABLE_DEPTH, divisor
  // zero acts as one.
  // --------------------------------------------------------------------------
  always_comb begin
    if (cfg_size_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(cfg_size_q) > TABLE_DEPTH) begin
      n_eff = NW'(TABLE_DEPTH);
    end else begin
      n_eff = NW'(cfg_size_q);
    end
    d_eff = (cfg_div_q == '0) ? DW'(1) : DW'(cfg_div_q);
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_size_d = cfg_size_q;
    cfg_div_d  = cfg_div_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegTableSize: cfg_size_d = cfg_data_i;
        RegHashDiv:   cfg_div_d  = cfg_data_i;
        default:      ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Shared remainder unit: first key mod divisor, then that mod table size.
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rem_start     = in_acc || ((state_q == S_DIV1) && rem_done);
  assign rem_dividend  = (state_q == S_IDLE) ? DVW'(s_axis_tdata[KEY_WIDTH-1:0])
                                             : DVW'(rem_val);
  assign rem_divisor   = (state_q == S_IDLE) ? d_eff : DW'(n_eff);

  qphs_rem #(
    .DIVIDEND_W (DVW),
    .DIVISOR_W  (DW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // --------------------------------------------------------------------------
  // Slot RAM: key and slot state side by side, state in the low bits.
  // --------------------------------------------------------------------------
  qphs_ram #(
    .WIDTH (RamW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_re  = (state_q == S_RD);
  assign rd_st   = slot_st_e'(ram_rdata[1:0]);
  // Stop at an empty slot or at any slot holding the key, tombstones included
  assign rd_stop = (rd_st == SLOT_EMPTY) || (ram_rdata[RamW-1:2] == key_q);

  // Next square mod n: (i-1)^2 + (2i-1) stays below 2n
  assign sq_sum  = {1'b0, sq_q} + odd_q;
  // Next probe position before the final wrap, below 2n either way
  assign pos_sum = plus_q ? ({1'b0, home_q} + {1'b0, sq_q})
                          : ({1'b0, home_q} + {1'b0, n_eff} - {1'b0, sq_q});

  assign out_free = !out_valid_q || m_axis_tready;
  assign slot_ext = {{SlotW{1'b0}}, cur_q};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    op_d         = op_q;
    key_d        = key_q;
    home_d       = home_q;
    cur_d        = cur_q;
    sq_d         = sq_q;
    odd_d        = odd_q;
    cnt_d        = cnt_q;
    plus_d       = plus_q;
    hit_d        = hit_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q[AW-1:0];
    ram_wdata    = {key_q, SLOT_VALID};

    unique case (state_q)
      S_CLEAR: begin
        // Sweep every slot to empty
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = {{KEY_WIDTH{1'b0}}, SLOT_EMPTY};
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d    = op_e'(s_axis_tuser);
          key_d   = s_axis_tdata[KEY_WIDTH-1:0];
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (rem_done) begin
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        if (rem_done) begin
          home_d  = rem_val[NW-1:0];
          cur_d   = rem_val[NW-1:0];
          sq_d    = '0;
          odd_d   = (NW+1)'(1);
          cnt_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (rd_stop) begin
          hit_d   = 1'b1;
          st_d    = rd_st;
          state_d = S_FIN;
        end else if ((cnt_q + NW'(1)) == n_eff) begin
          // Probe limit reached
          hit_d   = 1'b0;
          st_d    = rd_st;
          state_d = S_FIN;
        end else begin
          // Even probe count steps forward with a new square, odd steps back
          plus_d = !cnt_q[0];
          if (!cnt_q[0]) begin
            sq_d  = (sq_sum >= {1'b0, n_eff}) ? NW'(sq_sum - {1'b0, n_eff})
                                              : sq_sum[NW-1:0];
            odd_d = odd_q + (NW+1)'(2);
          end
          cnt_d   = cnt_q + NW'(1);
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cur_d   = (pos_sum >= {1'b0, n_eff}) ? NW'(pos_sum - {1'b0, n_eff})
                                             : pos_sum[NW-1:0];
        state_d = S_RD;
      end
      S_FIN: begin
        // Hold until the output register can take the result
        if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = hit_q ? slot_ext[SlotW-1:0] : '0;
          case (op_q)
            OP_INSERT: begin
              if (!hit_q) begin
                out_status_d = RES_FULL;
              end else if (st_q == SLOT_VALID) begin
                out_status_d = RES_PRESENT;
              end else begin
                ram_we       = 1'b1;
                ram_wdata    = {key_q, SLOT_VALID};
                out_status_d = RES_INSERTED;
              end
            end
            OP_DELETE: begin
              if (hit_q && (st_q == SLOT_VALID)) begin
                ram_we       = 1'b1;
                ram_wdata    = {key_q, SLOT_DELETED};
                out_status_d = RES_DELETED;
              end else begin
                out_status_d = RES_NOT_PRESENT;
              end
            end
            default: begin
              // Lookup; the unused opcode acts the same
              out_status_d = (hit_q && (st_q == SLOT_VALID)) ? RES_FOUND : RES_NOT_FOUND;
            end
          endcase
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cfg_size_q  <= CfgResetVal;
      cfg_div_q   <= CfgResetVal;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cfg_size_q  <= cfg_size_d;
      cfg_div_q   <= cfg_div_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    home_q       <= home_d;
    cur_q        <= cur_d;
    sq_q         <= sq_d;
    odd_q        <= odd_d;
    cnt_q        <= cnt_d;
    plus_q       <= plus_d;
    hit_q        <= hit_d;
    st_q         <= st_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OutDataW'(out_slot_q);

endmodule
